FILE: src/isolated_pixel_smoother_core_defines.svh
// Assertion macros for the checker file of the smoother.
`ifndef ISOLATED_PIXEL_SMOOTHER_CORE_DEFINES_SVH
`define ISOLATED_PIXEL_SMOOTHER_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define IPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define IPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ips_pkg.sv
`default_nettype none

package ips_pkg;

  // Defaults of the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_PIXEL_BITS = 8;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 11;
  localparam int TOL_BITS      = 8;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE    = 2'd2;

  localparam logic [CFG_DATA_BITS-1:0] RST_FRAME_WIDTH  = 11'd30;
  localparam logic [CFG_DATA_BITS-1:0] RST_FRAME_HEIGHT = 11'd20;
  localparam logic [TOL_BITS-1:0]      RST_TOLERANCE    = 8'd1;

  // Result queue: one input item causes at most three result items.
  localparam int MAX_RESULTS  = 3;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_BITS   = 2;
  localparam int Q_CNT_BITS   = 3;

endpackage

`default_nettype wire

FILE: src/ips_line_ram.sv
`default_nettype none

module ips_line_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [ADDR_BITS-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [ADDR_BITS-1:0] raddr_i,
  output logic      [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/isolated_pixel_smoother_core.sv
// Isolated-pixel smoother: 4-neighbor impulse-noise removal on a raster pixel stream.
// Input channel (in_valid_i / in_stall_o / pixel_in_i) takes one pixel per item in
// raster order. Output channel (out_valid_o / out_stall_i) gives the filtered pixel
// with its row and column, last_of_run_o on the final result of an input item and
// end_of_frame_o on the bottom right pixel. The config port (cfg_valid_i/cfg_ready_o,
// always ready) sets frame width, frame height and tolerance; write it only while idle.
// Pixel (r, c) leaves once pixel (r+1, c) has been taken: one row of delay, and its
// result is registered in the result queue first. Bottom-row pixels follow one column
// behind their input, and the last input also flushes the final pixel.
// Throughput is one item per cycle on all rows but the bottom one while the output is
// not stalled; on the bottom row each item after the first causes two results (three
// on the last column), input stalls, and the rate is set by the single output port
// draining a four-entry result queue. Line storage is one RAM of {older, recent} pixel
// pairs with one write and one registered read per item, prefetched two columns ahead.
// Reset clears the counters and the queue and loads config defaults; the line RAM and
// pixel registers are not cleared. A stalled output holds its item; once the queue
// holds more than one result, in_stall_o stays high until it is back to one.
`default_nettype none

module isolated_pixel_smoother_core #(
  parameter int MAX_WIDTH  = ips_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ips_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = ips_pkg::DEF_PIXEL_BITS,
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT),
  localparam int COL_BITS  = $clog2(MAX_WIDTH)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ips_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [ips_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [PIXEL_BITS-1:0]             pixel_in_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [PIXEL_BITS-1:0]             pixel_out_o,
  output logic      [ROW_BITS-1:0]               out_row_o,
  output logic      [COL_BITS-1:0]               out_column_o,
  output logic                                   last_of_run_o,
  output logic                                   end_of_frame_o
);

  localparam int CFG_BITS = ips_pkg::CFG_DATA_BITS;
  localparam int TOL_BITS = ips_pkg::TOL_BITS;
  localparam int WCW      = (CFG_BITS > COL_BITS + 1) ? CFG_BITS : COL_BITS + 1;
  localparam int HCW      = (CFG_BITS > ROW_BITS + 1) ? CFG_BITS : ROW_BITS + 1;
  localparam int TW       = (PIXEL_BITS > TOL_BITS) ? PIXEL_BITS : TOL_BITS;
  localparam int SUM_BITS = PIXEL_BITS + 3;
  localparam int MAG_BITS = PIXEL_BITS + 2;
  localparam int Y_BITS   = PIXEL_BITS + 3;
  localparam int DIV3_SH  = PIXEL_BITS + 4;
  localparam int DIV3_MUL = ((2 ** DIV3_SH) + 2) / 3;
  localparam int PROD_BITS = Y_BITS + DIV3_SH;
  localparam int QP = ips_pkg::Q_PTR_BITS;
  localparam int QC = ips_pkg::Q_CNT_BITS;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pix;
    logic [ROW_BITS-1:0]   row;
    logic [COL_BITS-1:0]   col;
    logic                  last;
    logic                  eof;
  } res_t;

  // Replace the center by the rounded mean of its neighbors when every neighbor
  // differs from it by more than the tolerance.
  function automatic logic [PIXEL_BITS-1:0] smooth(
    input logic [PIXEL_BITS-1:0]      ctr,
    input logic [3:0][PIXEL_BITS-1:0] nb,
    input logic [3:0]                 use_nb,
    input logic [TOL_BITS-1:0]        tol
  );
    logic signed [PIXEL_BITS:0]   diff;
    logic [PIXEL_BITS-1:0]        dmag;
    logic signed [SUM_BITS-1:0]   sum;
    logic [MAG_BITS-1:0]          mag;
    logic [Y_BITS-1:0]            y;
    logic [PROD_BITS-1:0]         prod;
    logic [PIXEL_BITS-1:0]        q;
    logic [2:0]                   k;
    logic                         keep;
    keep = 1'b0;
    sum  = '0;
    k    = '0;
    for (int i = 0; i < 4; i++) begin
      diff = $signed({1'b0, ctr}) - $signed({1'b0, nb[i]});
      dmag = diff[PIXEL_BITS] ? PIXEL_BITS'(-diff) : diff[PIXEL_BITS-1:0];
      if (use_nb[i]) begin
        if (TW'(dmag) <= TW'(tol)) begin
          keep = 1'b1;
        end
        sum = sum + SUM_BITS'(diff);
        k   = k + 3'd1;
      end
    end
    mag  = sum[SUM_BITS-1] ? MAG_BITS'(-sum) : MAG_BITS'(sum);
    y    = '0;
    prod = '0;
    case (k)
      3'd2: begin
        y = Y_BITS'(mag) + Y_BITS'(1);
        q = PIXEL_BITS'(y >> 1);
      end
      3'd3: begin
        // (2|S| + 3) / 6 equals (|S| + 1) / 3, done by a reciprocal multiply.
        y    = Y_BITS'(mag) + Y_BITS'(1);
        prod = PROD_BITS'(y) * PROD_BITS'(DIV3_MUL);
        q    = PIXEL_BITS'(prod >> DIV3_SH);
      end
      default: begin
        y = Y_BITS'(mag) + Y_BITS'(2);
        q = PIXEL_BITS'(y >> 2);
      end
    endcase
    if (keep) begin
      return ctr;
    end
    return sum[SUM_BITS-1] ? ctr + q : ctr - q;
  endfunction

  // Configuration registers.
  logic [CFG_BITS-1:0] width_q, height_q;
  logic [TOL_BITS-1:0] tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ips_pkg::RST_FRAME_WIDTH;
      height_q <= ips_pkg::RST_FRAME_HEIGHT;
      tol_q    <= ips_pkg::RST_TOLERANCE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ips_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        ips_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        ips_pkg::REG_TOLERANCE:    tol_q    <= cfg_data_i[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamped frame limits.
  logic [WCW-1:0]      w_ext, w_lim;
  logic [HCW-1:0]      h_ext, h_lim;
  logic [COL_BITS-1:0] w_m1;
  logic [ROW_BITS-1:0] h_m1;

  always_comb begin
    w_ext = WCW'(width_q);
    h_ext = HCW'(height_q);
    if (w_ext < WCW'(2)) begin
      w_lim = WCW'(2);
    end else if (w_ext > WCW'(MAX_WIDTH)) begin
      w_lim = WCW'(MAX_WIDTH);
    end else begin
      w_lim = w_ext;
    end
    if (h_ext < HCW'(2)) begin
      h_lim = HCW'(2);
    end else if (h_ext > HCW'(MAX_HEIGHT)) begin
      h_lim = HCW'(MAX_HEIGHT);
    end else begin
      h_lim = h_ext;
    end
    w_m1 = COL_BITS'(w_lim - WCW'(1));
    h_m1 = ROW_BITS'(h_lim - HCW'(1));
  end

  // Handshakes and result queue control.
  logic          accept, pop;
  logic [QC-1:0] cnt_q;
  logic [QP-1:0] wr_ptr_q, rd_ptr_q;
  res_t          q_mem [ips_pkg::Q_DEPTH];

  assign in_stall_o  = cnt_q > QC'(ips_pkg::Q_DEPTH - ips_pkg::MAX_RESULTS);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;

  // Position and line state.
  logic [ROW_BITS-1:0]     row_q;
  logic [COL_BITS-1:0]     col_q;
  logic [2*PIXEL_BITS-1:0] cur_q, first_q, byp_q, ram_rdata, nxt_word, word_wr;
  logic [PIXEL_BITS-1:0]   pl_q, p1_q, p2_q;
  logic                    bypass_q;
  logic                    row_end, bottom;
  logic [PIXEL_BITS-1:0]   cur_old, cur_rec, nxt_rec;
  logic [COL_BITS-1:0]     ram_raddr;

  assign row_end  = col_q >= w_m1;
  assign bottom   = row_q >= h_m1;
  assign cur_old  = cur_q[2*PIXEL_BITS-1:PIXEL_BITS];
  assign cur_rec  = cur_q[PIXEL_BITS-1:0];
  assign nxt_word = bypass_q ? byp_q : ram_rdata;
  assign nxt_rec  = nxt_word[PIXEL_BITS-1:0];
  assign word_wr  = {cur_rec, pixel_in_i};

  // At a row end the next row starts at column 0, whose pair is held in first_q, and
  // column 1 is fetched; otherwise the fetch runs two columns ahead.
  assign ram_raddr = row_end ? COL_BITS'(1) : col_q + COL_BITS'(2);

  ips_line_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_ips_line_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (word_wr),
    .re_i    (accept),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      bypass_q <= 1'b0;
    end else if (accept) begin
      // A two-pixel row writes column 1 in the same cycle it is fetched.
      bypass_q <= row_end && (col_q == COL_BITS'(1));
      if (row_end) begin
        col_q <= '0;
        row_q <= bottom ? '0 : row_q + ROW_BITS'(1);
      end else begin
        col_q <= col_q + COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (row_end) begin
        cur_q <= (col_q == '0) ? word_wr : first_q;
      end else begin
        cur_q <= nxt_word;
      end
      if (col_q == '0) begin
        first_q <= word_wr;
      end
      byp_q <= word_wr;
      pl_q  <= cur_rec;
      p1_q  <= pixel_in_i;
      p2_q  <= p1_q;
    end
  end

  // The three possible results of an input item.
  logic [3:0][PIXEL_BITS-1:0] nb_a, nb_b, nb_c;
  logic [3:0]                 use_a, use_b, use_c;
  logic [2:0]                 vld;
  res_t [2:0]                 res;
  logic [QP-1:0]              off1, off2;
  logic [QC-1:0]              n_push;

  always_comb begin
    // Pixel one row up: above, below, left and right neighbors.
    nb_a  = {nxt_rec, pl_q, pixel_in_i, cur_old};
    use_a = {!row_end, col_q != '0, 1'b1, row_q >= ROW_BITS'(2)};
    // Bottom row, one column back: above, left and right.
    nb_b  = {{PIXEL_BITS{1'b0}}, pixel_in_i, p2_q, pl_q};
    use_b = {1'b0, 1'b1, col_q >= COL_BITS'(2), 1'b1};
    // Bottom row, last column: above and left.
    nb_c  = {{PIXEL_BITS{1'b0}}, {PIXEL_BITS{1'b0}}, p1_q, cur_rec};
    use_c = {1'b0, 1'b0, col_q != '0, 1'b1};

    vld[0] = row_q != '0;
    vld[1] = bottom && (col_q != '0);
    vld[2] = bottom && row_end;

    res[0].pix  = smooth(cur_rec, nb_a, use_a, tol_q);
    res[0].row  = row_q - ROW_BITS'(1);
    res[0].col  = col_q;
    res[0].last = vld[0] && !vld[1] && !vld[2];
    res[0].eof  = 1'b0;

    res[1].pix  = smooth(p1_q, nb_b, use_b, tol_q);
    res[1].row  = row_q;
    res[1].col  = col_q - COL_BITS'(1);
    res[1].last = vld[1] && !vld[2];
    res[1].eof  = 1'b0;

    res[2].pix  = smooth(pixel_in_i, nb_c, use_c, tol_q);
    res[2].row  = row_q;
    res[2].col  = col_q;
    res[2].last = vld[2];
    res[2].eof  = 1'b1;

    off1   = QP'(vld[0]);
    off2   = QP'(vld[0]) + QP'(vld[1]);
    n_push = QC'(vld[0]) + QC'(vld[1]) + QC'(vld[2]);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (vld[0]) begin
        q_mem[wr_ptr_q] <= res[0];
      end
      if (vld[1]) begin
        q_mem[wr_ptr_q + off1] <= res[1];
      end
      if (vld[2]) begin
        q_mem[wr_ptr_q + off2] <= res[2];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q <= cnt_q + (accept ? n_push : '0) - QC'(pop);
      if (accept) begin
        wr_ptr_q <= wr_ptr_q + QP'(n_push);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QP'(1);
      end
    end
  end

  assign pixel_out_o    = q_mem[rd_ptr_q].pix;
  assign out_row_o      = q_mem[rd_ptr_q].row;
  assign out_column_o   = q_mem[rd_ptr_q].col;
  assign last_of_run_o  = q_mem[rd_ptr_q].last;
  assign end_of_frame_o = q_mem[rd_ptr_q].eof;

endmodule

`default_nettype wire

FILE: src/ips_checker.sv
`default_nettype none
`include "isolated_pixel_smoother_core_defines.svh"

module ips_checker #(
  parameter int MAX_WIDTH  = ips_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ips_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = ips_pkg::DEF_PIXEL_BITS,
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT),
  localparam int COL_BITS  = $clog2(MAX_WIDTH)
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic [PIXEL_BITS-1:0]             pixel_in_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic [PIXEL_BITS-1:0]             pixel_out_o,
  input wire logic [ROW_BITS-1:0]               out_row_o,
  input wire logic [COL_BITS-1:0]               out_column_o,
  input wire logic                              last_of_run_o,
  input wire logic                              end_of_frame_o
);

  // A stalled result item stays valid and unchanged.
  `IPS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(pixel_out_o) && $stable(out_row_o) && $stable(out_column_o), "stalled result item changed")

  // A stalled input item stays valid and unchanged.
  `IPS_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i && $stable(pixel_in_i), "stalled input item changed")

  // The bottom right pixel is always the final result of its input item.
  `IPS_ASSERT_IMP(a_eof_last, clk_i, rst_ni, out_valid_o && end_of_frame_o, last_of_run_o, "end of frame without last of run")

  // Frames are at least two pixels wide and high, so the corner is never at zero.
  `IPS_ASSERT_IMP(a_eof_pos, clk_i, rst_ni, out_valid_o && end_of_frame_o, (out_row_o != '0) && (out_column_o != '0), "end of frame at row or column zero")

  // With nothing queued for output the input side must be open.
  `IPS_ASSERT_IMP(a_empty_open, clk_i, rst_ni, !out_valid_o, !in_stall_o, "input stalled with empty result queue")

endmodule

bind isolated_pixel_smoother_core ips_checker #(
  .MAX_WIDTH  (MAX_WIDTH),
  .MAX_HEIGHT (MAX_HEIGHT),
  .PIXEL_BITS (PIXEL_BITS)
) u_ips_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .pixel_in_i     (pixel_in_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pixel_out_o    (pixel_out_o),
  .out_row_o      (out_row_o),
  .out_column_o   (out_column_o),
  .last_of_run_o  (last_of_run_o),
  .end_of_frame_o (end_of_frame_o)
);

`default_nettype wire
